>>> hw/rtl/bwd_pkg.sv
// ----------------------------------------------------------------------------
// Blitter word datapath package
// Payload and register types, register indexes, control bit positions and
// the word shifter used by the datapath files.
// ----------------------------------------------------------------------------
package bwd_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_CONTROL_A = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CONTROL_B = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FIRST_MASK = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LAST_MASK = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_A_DEFAULT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_B_DEFAULT = 3'd5;

  localparam int unsigned UseABit = 11;
  localparam int unsigned UseBBit = 10;
  localparam int unsigned UseCBit = 9;
  localparam int unsigned UseDBit = 8;
  localparam int unsigned FciBit = 2;
  localparam int unsigned DescBit = 1;

  localparam logic [1:0] FILL_NONE = 2'd0;
  localparam logic [1:0] FILL_EXCL = 2'd1;

  localparam logic [WordW-1:0] WordOnes = 16'hFFFF;

  typedef struct packed {
    logic [WordW-1:0] a_word;
    logic [WordW-1:0] b_word;
    logic [WordW-1:0] c_word;
    logic             row_first;
    logic             row_last;
    logic             blit_start;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0] d_word;
    logic             d_write;
  } out_beat_t;

  typedef struct packed {
    logic [WordW-1:0] control_a;
    logic [WordW-1:0] control_b;
    logic [WordW-1:0] first_mask;
    logic [WordW-1:0] last_mask;
    logic [WordW-1:0] a_default;
    logic [WordW-1:0] b_default;
  } cfg_t;

  function automatic logic [WordW-1:0] shift_word(input logic [WordW-1:0] cur,
                                                   input logic [WordW-1:0] prev,
                                                   input logic [3:0]       sh,
                                                   input logic             desc);
    logic [2*WordW-1:0] cat;
    logic [2*WordW-1:0] w;
    if (desc) begin
      cat = {cur, prev};
      w   = cat >> (5'd16 - {1'b0, sh});
    end else begin
      cat = {prev, cur};
      w   = cat >> sh;
    end
    return w[WordW-1:0];
  endfunction

endpackage

>>> hw/rtl/blitter_word_datapath_top.sv
// ----------------------------------------------------------------------------
// Blitter word datapath top level
// Per-word source masking, shifting, minterm and fill of a bitplane blitter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one beat per
//   destination word: A, B and C source words and row and blit flags.
//   Output channel (out_valid_o / out_stall_i / out_data_o) gives one beat
//   per input beat, in order: the destination word and its write enable.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes the six control
//   registers by index; ready is always high. Write only while idle.
//   A beat accepted into the input register moves to the result register
//   once that register is free, and is offered on the output from there.
//   Throughput: one beat per cycle unless the output stalls; hold words and
//   fill carry update in the single stage between input and result registers.
//   Reset clears both stages, the hold words and the fill carry; the masks
//   come up as all ones and the other registers as zero.
//   A stall on the output holds the result register; the input register
//   still takes a beat while it is empty, then the input channel stalls.
// ----------------------------------------------------------------------------
module blitter_word_datapath_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bwd_pkg::in_beat_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bwd_pkg::out_beat_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bwd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bwd_pkg::WordW-1:0]    cfg_data_i
);

  bwd_pkg::cfg_t     cfg;
  bwd_pkg::in_beat_t s1_q;
  logic              s1_valid_q;
  logic              out_valid_q;
  bwd_pkg::out_beat_t out_q, out_d;

  logic [bwd_pkg::WordW-1:0] a_hold_q, a_hold_d, b_hold_q, b_hold_d;
  logic                      carry_q, carry_d;

  logic                      out_free, advance, accept;
  logic                      any_use;
  logic [bwd_pkg::WordW-1:0] a_prev, b_prev, raw_a, raw_b, cw, a_sh, b_sh, d_word;
  logic                      carry_start, carry_next;

  bwd_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign any_use = cfg.control_a[bwd_pkg::UseABit] | cfg.control_a[bwd_pkg::UseBBit]
                 | cfg.control_a[bwd_pkg::UseCBit] | cfg.control_a[bwd_pkg::UseDBit];

  always_comb begin
    a_prev = s1_q.blit_start ? '0 : a_hold_q;
    b_prev = s1_q.blit_start ? '0 : b_hold_q;
    raw_a  = cfg.control_a[bwd_pkg::UseABit] ? s1_q.a_word : cfg.a_default;
    if (s1_q.row_first) begin
      raw_a = raw_a & cfg.first_mask;
    end
    if (s1_q.row_last) begin
      raw_a = raw_a & cfg.last_mask;
    end
    raw_b = cfg.control_a[bwd_pkg::UseBBit] ? s1_q.b_word : cfg.b_default;
    cw    = cfg.control_a[bwd_pkg::UseCBit] ? s1_q.c_word : '0;
    a_sh  = bwd_pkg::shift_word(raw_a, a_prev, cfg.control_a[15:12],
                                cfg.control_b[bwd_pkg::DescBit]);
    b_sh  = bwd_pkg::shift_word(raw_b, b_prev, cfg.control_b[15:12],
                                cfg.control_b[bwd_pkg::DescBit]);
    carry_start = s1_q.row_first ? cfg.control_b[bwd_pkg::FciBit] : carry_q;
  end

  bwd_func u_func (
    .a_i       (a_sh),
    .b_i       (b_sh),
    .c_i       (cw),
    .minterm_i (cfg.control_a[7:0]),
    .fill_i    (cfg.control_b[3:2]),
    .carry_i   (carry_start),
    .d_o       (d_word),
    .carry_o   (carry_next)
  );

  always_comb begin
    a_hold_d = a_hold_q;
    b_hold_d = b_hold_q;
    carry_d  = carry_q;
    out_d    = out_q;
    if (advance) begin
      if (any_use) begin
        a_hold_d      = raw_a;
        b_hold_d      = raw_b;
        carry_d       = carry_next;
        out_d.d_word  = d_word;
        out_d.d_write = cfg.control_a[bwd_pkg::UseDBit];
      end else begin
        out_d.d_word  = '0;
        out_d.d_write = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      a_hold_q    <= '0;
      b_hold_q    <= '0;
      carry_q     <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      a_hold_q <= a_hold_d;
      b_hold_q <= b_hold_d;
      carry_q  <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_needs_full_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while result register empty");

  a_advance_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !in_stall_o) |=> out_valid_o)
    else $error("staged beat lost on its way to the result register");

  a_write_needs_d : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.d_write) |-> cfg.control_a[bwd_pkg::UseDBit])
    else $error("write enable without channel D enabled");

endmodule

>>> hw/rtl/bwd_regs.sv
// ----------------------------------------------------------------------------
// Blitter word datapath register file
// Six 16-bit control registers written through the configuration channel.
// ----------------------------------------------------------------------------
module bwd_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bwd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bwd_pkg::WordW-1:0]    cfg_data_i,
  output bwd_pkg::cfg_t                cfg_o
);

  bwd_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bwd_pkg::REG_CONTROL_A:  cfg_d.control_a  = cfg_data_i;
        bwd_pkg::REG_CONTROL_B:  cfg_d.control_b  = cfg_data_i;
        bwd_pkg::REG_FIRST_MASK: cfg_d.first_mask = cfg_data_i;
        bwd_pkg::REG_LAST_MASK:  cfg_d.last_mask  = cfg_data_i;
        bwd_pkg::REG_A_DEFAULT:  cfg_d.a_default  = cfg_data_i;
        bwd_pkg::REG_B_DEFAULT:  cfg_d.b_default  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_a  <= '0;
      cfg_q.control_b  <= '0;
      cfg_q.first_mask <= bwd_pkg::WordOnes;
      cfg_q.last_mask  <= bwd_pkg::WordOnes;
      cfg_q.a_default  <= '0;
      cfg_q.b_default  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/bwd_func.sv
// ----------------------------------------------------------------------------
// Blitter word datapath logic function
// Minterm over the shifted A and B words and the C word, then optional area fill.
// ----------------------------------------------------------------------------
module bwd_func (
  input  logic [bwd_pkg::WordW-1:0] a_i,
  input  logic [bwd_pkg::WordW-1:0] b_i,
  input  logic [bwd_pkg::WordW-1:0] c_i,
  input  logic [7:0]                minterm_i,
  input  logic [1:0]                fill_i,
  input  logic                      carry_i,
  output logic [bwd_pkg::WordW-1:0] d_o,
  output logic                      carry_o
);

  logic [bwd_pkg::WordW-1:0] mt;
  logic [bwd_pkg::WordW-1:0] prefix;
  logic [bwd_pkg::WordW-1:0] incl_carry;

  always_comb begin
    for (int i = 0; i < bwd_pkg::WordW; i++) begin
      mt[i] = minterm_i[{a_i[i], b_i[i], c_i[i]}];
    end
  end

  // running carry after each bit, computed per bit
  always_comb begin
    for (int i = 0; i < bwd_pkg::WordW; i++) begin
      prefix[i] = carry_i ^ (^(mt & (bwd_pkg::WordOnes >> (bwd_pkg::WordW - 1 - i))));
    end
  end

  assign incl_carry = {prefix[bwd_pkg::WordW-2:0], carry_i};

  always_comb begin
    case (fill_i)
      bwd_pkg::FILL_NONE: begin
        d_o     = mt;
        carry_o = carry_i;
      end
      bwd_pkg::FILL_EXCL: begin
        d_o     = prefix;
        carry_o = prefix[bwd_pkg::WordW-1];
      end
      default: begin
        d_o     = mt | incl_carry;
        carry_o = prefix[bwd_pkg::WordW-1];
      end
    endcase
  end

endmodule
